/* src/pecc_pkg.sv */
// Shared types and constants for the PE image check and checksum block.
// Holds the header field slot map used by the top level and the DOS window.
// No dependencies.
package pecc_pkg;

  // Length of the DOS header area, kept until the header offset is known
  localparam int unsigned DosArea = 64;

  // Data directory entry checked for base relocations
  localparam int unsigned RelocDirIndex = 5;

  // Header field bytes tracked, one slot per byte
  localparam int unsigned NumSlots = 24;

  // First slot of each captured field (little-endian, low byte first)
  localparam int unsigned SlotSig       = 0;
  localparam int unsigned SlotSect      = 4;
  localparam int unsigned SlotOptMagic  = 6;
  localparam int unsigned SlotCsum      = 8;
  localparam int unsigned SlotDirCnt    = 12;
  localparam int unsigned SlotRelocRva  = 16;
  localparam int unsigned SlotRelocSize = 20;

  // Byte writes into the field slots
  typedef struct packed {
    logic [NumSlots-1:0]      en;
    logic [NumSlots-1:0][7:0] data;
  } fld_wr_t;

  // Offset of a slot's byte from the PE header offset
  function automatic logic [7:0] slot_offset(input int unsigned slot);
    int unsigned rd;
    int unsigned off;
    rd = 120 + 8 * RelocDirIndex;
    if (slot < SlotSect) begin
      off = slot;
    end else if (slot < SlotOptMagic) begin
      off = 6 + slot - SlotSect;
    end else if (slot < SlotCsum) begin
      off = 24 + slot - SlotOptMagic;
    end else if (slot < SlotDirCnt) begin
      off = 88 + slot - SlotCsum;
    end else if (slot < SlotRelocRva) begin
      off = 116 + slot - SlotDirCnt;
    end else begin
      // rva and size words sit back to back in the directory entry
      off = rd + slot - SlotRelocRva;
    end
    return off[7:0];
  endfunction

endpackage

/* src/pecc_dos_window.sv */
// DOS header window: shift line holding the first 64 image bytes.
// Once the header offset is known, it resolves header fields lying inside the area.
// Depends on pecc_pkg.
module pecc_dos_window (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_en_i,
  input  logic [7:0]        byte_i,
  input  logic              start_i,
  input  logic [31:0]       hdr_offset_i,
  output logic              busy_o,
  output pecc_pkg::fld_wr_t wr_o
);

  localparam int unsigned IdxW = $clog2(pecc_pkg::DosArea);

  logic [pecc_pkg::DosArea-1:0][7:0] line_q;
  logic                              busy_q;
  logic [IdxW-1:0]                   cnt_q;
  logic [IdxW-1:0]                   base_q;
  logic                              fire;

  // Line is aligned to the header offset once the count runs out
  assign fire   = busy_q && (cnt_q == '0);
  assign busy_o = busy_q;

  // Shift in image bytes, then advance by one byte per cycle toward the header
  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      line_q <= {byte_i, line_q[pecc_pkg::DosArea-1:1]};
    end else if (busy_q && !fire) begin
      line_q <= {8'h00, line_q[pecc_pkg::DosArea-1:1]};
    end
  end

  // Arm on the last DOS byte when the header starts inside the area
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      base_q <= '0;
    end else if (start_i) begin
      busy_q <= (hdr_offset_i[31:IdxW] == '0);
      cnt_q  <= hdr_offset_i[IdxW-1:0];
      base_q <= hdr_offset_i[IdxW-1:0];
    end else if (fire) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Write each slot whose byte lies inside the DOS area
  always_comb begin
    logic [7:0] off;
    logic [8:0] reach;
    wr_o = '0;
    for (int s = 0; s < pecc_pkg::NumSlots; s++) begin
      off          = pecc_pkg::slot_offset(s);
      reach        = {1'b0, off} + {{(9-IdxW){1'b0}}, base_q};
      wr_o.en[s]   = fire && (reach < 9'(pecc_pkg::DosArea));
      wr_o.data[s] = line_q[off[IdxW-1:0]];
    end
  end

endmodule

/* src/pe_image_check_and_checksum.sv */
// PE32 image header check and checksum, top level.
// Depends on pecc_pkg and pecc_dos_window.
//
// Usage: the image enters on the s_axis channel, one byte per word in file order,
// with s_axis_tlast on the final byte. One result word leaves on m_axis per image,
// after its last byte: header status, stored and computed checksums, match flag
// and section count.
// Throughput: one byte per cycle while an image streams. After the last byte the
// input is held off while the result is finished in the StFinA and StFinB states,
// and the result word is then loaded into the output register.
// When the PE header offset lies inside the 64-byte DOS area, the DOS window
// counts down from the offset after byte 63 to resolve overlapping fields; an image
// that ends before that waits for it before its result is finished.
// The result sits in an output register: the next image streams in while it waits.
// If the receiver stalls and a second result is ready, input is held off until
// the first result is taken.
// Reset clears all image state; the first byte after reset starts a new image,
// and so does the first byte after each result.
module pe_image_check_and_checksum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata    // [3:0] status, [4] checksum_match,
                                      // [36:5] stored_checksum,
                                      // [68:37] computed_checksum,
                                      // [84:69] section_count, [87:85] zero
);

  localparam int unsigned IdxW = $clog2(pecc_pkg::DosArea);

  typedef enum logic [1:0] {
    StRun,
    StFinA,
    StFinB
  } state_e;

  typedef enum logic [3:0] {
    StatOk          = 4'd0,
    StatShortDos    = 4'd1,
    StatBadDosMagic = 4'd2,
    StatNoSig       = 4'd3,
    StatBadSig      = 4'd4,
    StatNoCoff      = 4'd5,
    StatNoStdOpt    = 4'd6,
    StatBadOptMagic = 4'd7,
    StatNoWinOpt    = 4'd8,
    StatNoDirs      = 4'd9,
    StatReloc       = 4'd10,
    StatTooLong     = 4'd11
  } status_e;

  function automatic logic [15:0] fold_add(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    logic [16:0] u;
    t = {1'b0, s} + {1'b0, w};
    u = t + {16'h0000, t[16]};
    return u[15:0];
  endfunction

  state_e  state_q;
  logic    accept;
  logic    load;
  logic    in_dos;
  logic    start;
  logic    shift_en;
  logic    csum_zero;
  logic    res_busy;
  logic [7:0]  b_eff;
  logic [33:0] rel;
  logic        in_rng;

  logic [32:0] pos_q;
  logic [15:0] sum_q;
  logic [7:0]  held_q;
  logic [15:0] magic_q;
  logic [31:0] hdr_q;
  logic [pecc_pkg::NumSlots-1:0][7:0] fld_q;

  pecc_pkg::fld_wr_t res_wr;
  pecc_pkg::fld_wr_t str_wr;

  logic [31:0] sig;
  logic [15:0] sect;
  logic [15:0] opt_magic;
  logic [31:0] csum;
  logic [31:0] dir_cnt;
  logic [31:0] reloc_rva;
  logic [31:0] reloc_size;

  logic [15:0] sfin_q;
  logic [34:0] dlen_q;
  logic [36:0] bound_q;

  status_e     status;
  logic [31:0] computed;
  logic        st_ok;

  logic        out_valid_q;
  logic [87:0] out_data_q;

  // Handshake
  assign s_axis_tready = (state_q == StRun);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load          = (state_q == StFinB) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Position relative to the PE header, for bytes past the DOS area
  assign in_dos   = (pos_q[32:IdxW] == '0);
  assign start    = accept && (pos_q == 33'(pecc_pkg::DosArea - 1));
  assign shift_en = accept && in_dos;
  assign rel      = {1'b0, pos_q} - {2'b00, hdr_q};
  assign in_rng   = !in_dos && (rel[33:8] == '0);

  always_comb begin
    for (int s = 0; s < pecc_pkg::NumSlots; s++) begin
      str_wr.en[s]   = accept && in_rng && (rel[7:0] == pecc_pkg::slot_offset(s));
      str_wr.data[s] = s_axis_tdata;
    end
  end

  // Checksum field bytes count as zero in the sum
  assign csum_zero = |str_wr.en[pecc_pkg::SlotCsum+3:pecc_pkg::SlotCsum];
  assign b_eff     = csum_zero ? 8'h00 : s_axis_tdata;

  pecc_dos_window u_dos_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .shift_en_i   (shift_en),
    .byte_i       (s_axis_tdata),
    .start_i      (start),
    .hdr_offset_i ({s_axis_tdata, hdr_q[23:0]}),
    .busy_o       (res_busy),
    .wr_o         (res_wr)
  );

  // Image state: position, word sum, fixed-position captures, field slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sum_q   <= '0;
      held_q  <= '0;
      magic_q <= '0;
      hdr_q   <= '0;
      fld_q   <= '0;
    end else if (load) begin
      pos_q   <= '0;
      sum_q   <= '0;
      held_q  <= '0;
      magic_q <= '0;
      hdr_q   <= '0;
      fld_q   <= '0;
    end else begin
      if (accept) begin
        if (!pos_q[32]) begin
          pos_q <= pos_q + 33'd1;
        end
        if (!pos_q[0]) begin
          held_q <= b_eff;
        end else begin
          sum_q <= fold_add(sum_q, {b_eff, held_q});
        end
        if (in_dos && (pos_q[IdxW-1:1] == '0)) begin
          magic_q[8*pos_q[0] +: 8] <= s_axis_tdata;
        end
        if (in_dos && (pos_q[IdxW-1:2] == '1)) begin
          hdr_q[8*pos_q[1:0] +: 8] <= s_axis_tdata;
        end
      end
      for (int s = 0; s < pecc_pkg::NumSlots; s++) begin
        if (res_wr.en[s]) begin
          fld_q[s] <= res_wr.data[s];
        end else if (str_wr.en[s]) begin
          fld_q[s] <= str_wr.data[s];
        end
      end
    end
  end

  // Field views
  assign sig        = fld_q[pecc_pkg::SlotSig+3 -: 4];
  assign sect       = fld_q[pecc_pkg::SlotSect+1 -: 2];
  assign opt_magic  = fld_q[pecc_pkg::SlotOptMagic+1 -: 2];
  assign csum       = fld_q[pecc_pkg::SlotCsum+3 -: 4];
  assign dir_cnt    = fld_q[pecc_pkg::SlotDirCnt+3 -: 4];
  assign reloc_rva  = fld_q[pecc_pkg::SlotRelocRva+3 -: 4];
  assign reloc_size = fld_q[pecc_pkg::SlotRelocSize+3 -: 4];

  // Header checks in file order
  always_comb begin
    if (pos_q[32]) begin
      status = StatTooLong;
    end else if (pos_q < 33'(pecc_pkg::DosArea)) begin
      status = StatShortDos;
    end else if (magic_q != 16'h5A4D) begin
      status = StatBadDosMagic;
    end else if (dlen_q[34] || (dlen_q[33:0] < 34'd4)) begin
      status = StatNoSig;
    end else if (sig != 32'h0000_4550) begin
      status = StatBadSig;
    end else if (dlen_q[33:0] < 34'd24) begin
      status = StatNoCoff;
    end else if (dlen_q[33:0] < 34'd52) begin
      status = StatNoStdOpt;
    end else if (opt_magic != 16'h010B) begin
      status = StatBadOptMagic;
    end else if (dlen_q[33:0] < 34'd120) begin
      status = StatNoWinOpt;
    end else if ({4'h0, pos_q} < bound_q) begin
      status = StatNoDirs;
    end else if ((dir_cnt > 32'(pecc_pkg::RelocDirIndex)) && (reloc_rva != '0) &&
                 (reloc_size != '0)) begin
      status = StatReloc;
    end else begin
      status = StatOk;
    end
  end

  assign computed = {16'h0000, sfin_q} + pos_q[31:0];
  assign st_ok    = (status == StatOk);

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRun;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      sfin_q      <= '0;
      dlen_q      <= '0;
      bound_q     <= '0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StRun: begin
          if (accept && s_axis_tlast) begin
            state_q <= StFinA;
          end
        end
        StFinA: begin
          // Fold in an odd final byte and form the header bounds
          if (!res_busy) begin
            sfin_q  <= pos_q[0] ? fold_add(sum_q, {8'h00, held_q}) : sum_q;
            dlen_q  <= {2'b00, pos_q} - {3'b000, hdr_q};
            bound_q <= {5'b00000, hdr_q} + 37'd120 + {2'b00, dir_cnt, 3'b000} +
                       {16'h0000, sect, 5'b00000} + {18'h00000, sect, 3'b000};
            state_q <= StFinB;
          end
        end
        StFinB: begin
          if (load) begin
            out_data_q <= {3'b000,
                           ((st_ok || (status == StatNoDirs) || (status == StatReloc)) ?
                            sect : 16'h0000),
                           (st_ok ? computed : 32'h0000_0000),
                           (st_ok ? csum : 32'h0000_0000),
                           (st_ok && (computed == csum)),
                           status};
            out_valid_q <= 1'b1;
            state_q     <= StRun;
          end
        end
        default: begin
          state_q <= StRun;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_slot_writers_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_wr.en & str_wr.en) == '0)
    else $error("DOS window and stream wrote the same header slot");

  a_window_idle_in_dos_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_busy |-> !shift_en)
    else $error("DOS window resolving while DOS area bytes still arrive");

  a_finish_after_resolve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinB) |-> !res_busy)
    else $error("result finished before DOS window resolved");

  a_state_cleared_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> ((pos_q == '0) && (sum_q == '0) && (hdr_q == '0)))
    else $error("image state not cleared after result");
`endif

endmodule
